FILE: sv/value_noise_2d_direction_assert.svh
// assertion macros shared by the value noise block
// depends on nothing; taken in by the files that carry concurrent checks
`ifndef VALUE_NOISE_2D_DIRECTION_ASSERT_SVH
`define VALUE_NOISE_2D_DIRECTION_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define VN2D_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define VN2D_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/vn2d_pkg.sv
// shared constants, types and the sine table builder for the value noise block
// depends on nothing; used by every module of the block
package vn2d_pkg;

    // seed grid geometry
    localparam int GRID_LOG2 = 6;
    localparam int GRID_SIDE = 1 << GRID_LOG2;
    localparam int ADDR_W    = 2 * GRID_LOG2;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int SEED_W    = 16;
    localparam int SH_W      = 4;

    // direction table
    localparam int SINE_DEPTH_DEF = 256;
    localparam int SINE_W         = 15;
    localparam logic [SINE_W-1:0] ONE_Q14 = 15'd16384;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:7] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    // configuration registers
    localparam int OCT_W      = 3;
    localparam int BIAS_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALING_BIAS = 1'd1;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 3'd2;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd768;
    localparam logic [BIAS_W-1:0] MIN_BIAS   = 16'd51;

    // item kinds
    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // datapath widths
    localparam int W_W    = 32;
    localparam int WSUM_W = 35;
    localparam int NSUM_W = 51;
    localparam int ACC_W  = 29;
    localparam int MUL_AW = 32;
    localparam int MUL_BW = 16;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam logic [W_W-1:0] W_ONE = 32'h0001_0000;

    // shared divider
    localparam int DIV_DW = 52;
    localparam int DIV_VW = 35;
    localparam int DIV_CW = 6;
    localparam logic [DIV_CW-1:0] W_DIV_ITERS = 6'd40;
    localparam logic [DIV_CW-1:0] F_DIV_ITERS = 6'd52;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] iters;
    } t_div_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OCT,
        ST_CW,
        ST_CS,
        ST_CA,
        ST_SMP,
        ST_NACC,
        ST_WDIV,
        ST_FGO,
        ST_FDIV,
        ST_DGO,
        ST_DIR,
        ST_OUT
    } t_state;

    // quarter-wave sine entry in Q1.14 from a Q2.30 angle, elaboration only
    function automatic logic [SINE_W-1:0] sine_entry(input longint unsigned theta);
        longint unsigned sq;
        longint unsigned term;
        longint unsigned u;
        longint unsigned v;
        longint          sum;
        sq   = (theta * theta) >> 30;
        term = theta;
        sum  = longint'(theta);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * sq) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        u = (sum < 0) ? 64'd0 : longint'(sum);
        v = (u * 64'd16384 + (64'd1 << 29)) >> 30;
        if (v > 64'd16384) begin
            v = 64'd16384;
        end
        return SINE_W'(v);
    endfunction

endpackage

FILE: sv/vn2d_seed_ram.sv
// seed grid storage: one write port, one registered read port
// depends on vn2d_pkg for the grid size and seed width
module vn2d_seed_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [vn2d_pkg::ADDR_W-1:0] i_waddr,
    input  logic [vn2d_pkg::SEED_W-1:0] i_wdata,
    input  logic [vn2d_pkg::ADDR_W-1:0] i_raddr,
    output logic [vn2d_pkg::SEED_W-1:0] o_rdata
);

    logic [vn2d_pkg::SEED_W-1:0] r_mem [vn2d_pkg::CELLS];
    logic [vn2d_pkg::SEED_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/vn2d_divider.sv
// shared restoring divider, one quotient bit per cycle
// depends on vn2d_pkg for widths and the request struct
module vn2d_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vn2d_pkg::t_div_req          i_req,
    input  logic [vn2d_pkg::DIV_DW-1:0] i_dividend,
    input  logic [vn2d_pkg::DIV_VW-1:0] i_divisor,
    output logic [vn2d_pkg::DIV_DW-1:0] o_quotient,
    output logic                        o_done,
    output logic                        o_busy
);

    localparam int DW = vn2d_pkg::DIV_DW;
    localparam int VW = vn2d_pkg::DIV_VW;

    logic                        r_busy;
    logic                        r_done;
    logic [vn2d_pkg::DIV_CW-1:0] r_cnt;
    logic [DW-1:0]               r_dvd;
    logic [VW-1:0]               r_dvs;
    logic [VW-1:0]               r_rem;
    logic [DW-1:0]               r_quo;

    logic [VW:0] w_rem_sh;
    logic [VW:0] w_rem_nx;
    logic        w_ge;

    // one restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        w_rem_sh = {r_rem, r_dvd[DW-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_dvs});
        w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
    end

    // step counter and completion flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == vn2d_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= w_rem_nx[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;
    assign o_busy     = r_busy;

endmodule

FILE: sv/vn2d_dir_lut.sv
// noise value to unit direction: phase rounding, quadrant fold, sine table
// depends on vn2d_pkg for the table builder and Q1.14 constants
module vn2d_dir_lut #(
    parameter int SINE_TABLE_DEPTH = vn2d_pkg::SINE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_value,
    output logic               o_done,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y
);

    localparam int TURN = 4 * SINE_TABLE_DEPTH;
    localparam int PW   = $clog2(TURN);
    localparam int KW   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IW   = $clog2(SINE_TABLE_DEPTH);
    localparam int MW   = 16 + PW + 1;
    localparam logic [MW-1:0] TURN_M = MW'(TURN);
    localparam logic [MW-1:0] HALF_M = MW'(32768);
    localparam logic [PW:0]   D1 = (PW + 1)'(SINE_TABLE_DEPTH);
    localparam logic [PW:0]   D2 = (PW + 1)'(2 * SINE_TABLE_DEPTH);
    localparam logic [PW:0]   D3 = (PW + 1)'(3 * SINE_TABLE_DEPTH);
    localparam logic [PW:0]   D4 = (PW + 1)'(TURN);
    localparam logic [KW-1:0] K_TOP = KW'(SINE_TABLE_DEPTH);

    logic [vn2d_pkg::SINE_W-1:0] w_lut [SINE_TABLE_DEPTH];

    // constant quarter-wave table, built at elaboration
    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_lut
        localparam longint unsigned THETA =
            vn2d_pkg::HALF_PI_Q30 * i / SINE_TABLE_DEPTH;
        assign w_lut[i] = vn2d_pkg::sine_entry(THETA);
    end

    logic [MW-1:0] w_prod;
    logic [PW:0]   w_n_raw;
    logic [PW:0]   w_ns;
    logic [PW:0]   w_nc_t;
    logic [PW:0]   w_nc;
    logic [PW:0]   w_phase [2];

    // phase step of a full turn, sine phase and cosine phase
    always_comb begin
        w_prod  = MW'(i_value) * TURN_M + HALF_M;
        w_n_raw = w_prod[MW-1:16];
        w_ns    = (w_n_raw >= D4) ? (w_n_raw - D4) : w_n_raw;
        w_nc_t  = w_ns + D1;
        w_nc    = (w_nc_t >= D4) ? (w_nc_t - D4) : w_nc_t;
    end

    assign w_phase[0] = w_ns;
    assign w_phase[1] = w_nc;

    logic          r_v1;
    logic          r_v2;
    logic [KW-1:0] r_k   [2];
    logic          r_neg [2];
    logic [15:0]   r_dir [2];

    // lane 0 is sine, lane 1 is cosine
    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic                        w_ge1;
        logic                        w_ge2;
        logic                        w_ge3;
        logic [PW:0]                 w_base;
        logic [PW:0]                 w_rem;
        logic [PW:0]                 w_mir;
        logic [KW-1:0]               w_k;
        logic [vn2d_pkg::SINE_W-1:0] w_mag;

        // quadrant fold onto the quarter wave
        always_comb begin
            w_ge1 = (w_phase[g] >= D1);
            w_ge2 = (w_phase[g] >= D2);
            w_ge3 = (w_phase[g] >= D3);
            priority if (w_ge3) begin
                w_base = D3;
            end else if (w_ge2) begin
                w_base = D2;
            end else if (w_ge1) begin
                w_base = D1;
            end else begin
                w_base = '0;
            end
            w_rem = w_phase[g] - w_base;
            w_mir = D1 - w_rem;
            w_k   = (w_ge1 ^ w_ge2 ^ w_ge3) ? KW'(w_mir) : KW'(w_rem);
        end

        // table read, the top of the quarter wave is one
        always_comb begin
            if (r_k[g] == K_TOP) begin
                w_mag = vn2d_pkg::ONE_Q14;
            end else begin
                w_mag = w_lut[r_k[g][IW-1:0]];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_k[g]   <= w_k;
                r_neg[g] <= w_ge2;
            end
            if (r_v1) begin
                r_dir[g] <= r_neg[g] ? (16'd0 - {1'b0, w_mag}) : {1'b0, w_mag};
            end
        end
    end

    // two-stage valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    assign o_done  = r_v2;
    assign o_dir_x = signed'(r_dir[1]);
    assign o_dir_y = signed'(r_dir[0]);

endmodule

FILE: sv/value_noise_2d_direction.sv
// Write item: the seed is written when the item is taken, and the next item can be taken in the following cycle.
// Compute item: each octave blends its four corner seeds and adds the weighted sample,
// then, for every octave but the last, the bit-serial divider updates the weight; after
// the last octave it normalizes the sum, and the direction table runs last. Zero octaves: direction lookup only.
// Reset: octave_count 2, scaling_bias 768, output empty; seed grid keeps contents.
// Depends on vn2d_pkg, vn2d_seed_ram, vn2d_divider, vn2d_dir_lut and the assert header.
`include "value_noise_2d_direction_assert.svh"

module value_noise_2d_direction #(
    parameter int SINE_TABLE_DEPTH = vn2d_pkg::SINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // grid_x[5:0], grid_y[11:6], seed_value[27:12]
    input  logic [0:0]  s_axis_tuser,   // command[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // noise_value[15:0], dir_x[31:16], dir_y[47:32]
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vn2d_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vn2d_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int GL     = vn2d_pkg::GRID_LOG2;
    localparam int ACC_W  = vn2d_pkg::ACC_W;
    localparam int MUL_PW = vn2d_pkg::MUL_PW;
    localparam int DIV_DW = vn2d_pkg::DIV_DW;
    localparam logic [GL:0] PITCH0 = (GL + 1)'(vn2d_pkg::GRID_SIDE);
    localparam logic [vn2d_pkg::SH_W-1:0] SHIFT0 = vn2d_pkg::SH_W'(2 * GL);

    // input fields
    logic [GL-1:0]               w_in_x;
    logic [GL-1:0]               w_in_y;
    logic [vn2d_pkg::SEED_W-1:0] w_in_seed;
    logic                        w_in_cmd;
    logic                        w_in_xfer;

    assign w_in_x    = s_axis_tdata[5:0];
    assign w_in_y    = s_axis_tdata[11:6];
    assign w_in_seed = s_axis_tdata[27:12];
    assign w_in_cmd  = s_axis_tuser[0];
    assign w_in_xfer = s_axis_tvalid && s_axis_tready;

    // control registers
    vn2d_pkg::t_state              r_state;
    vn2d_pkg::t_state              n_state;
    logic                          r_out_valid;
    logic [vn2d_pkg::OCT_W-1:0]    r_cfg_oct;
    logic [vn2d_pkg::BIAS_W-1:0]   r_cfg_bias;

    // datapath registers
    logic [GL-1:0]                 r_x;
    logic [GL-1:0]                 r_y;
    logic [vn2d_pkg::OCT_W-1:0]    r_cnt;
    logic [vn2d_pkg::BIAS_W-1:0]   r_bias;
    logic [vn2d_pkg::OCT_W-1:0]    r_oct;
    logic [1:0]                    r_k;
    logic [GL-1:0]                 r_x1;
    logic [GL-1:0]                 r_x2;
    logic [GL-1:0]                 r_y1;
    logic [GL-1:0]                 r_y2;
    logic [GL:0]                   r_fx0;
    logic [GL:0]                   r_fx1;
    logic [GL:0]                   r_fy0;
    logic [GL:0]                   r_fy1;
    logic [vn2d_pkg::SH_W-1:0]     r_shift;
    logic [ACC_W-1:0]              r_acc;
    logic [MUL_PW-1:0]             r_prod;
    logic [vn2d_pkg::W_W-1:0]      r_w;
    logic [vn2d_pkg::WSUM_W-1:0]   r_wsum;
    logic [vn2d_pkg::NSUM_W-1:0]   r_nsum;
    logic [15:0]                   r_value;
    logic [47:0]                   r_out_data;

    // sequencer outputs
    logic w_out_load;
    logic w_dir_start;
    logic w_ram_we;
    logic w_last;

    // submodule signals
    logic [vn2d_pkg::SEED_W-1:0]   w_rd_data;
    vn2d_pkg::t_div_req            w_div_req;
    logic [DIV_DW-1:0]             w_div_dvd;
    logic [vn2d_pkg::DIV_VW-1:0]   w_div_dvs;
    logic [DIV_DW-1:0]             w_div_quo;
    logic                          w_div_done;
    logic                          w_div_busy;
    logic                          w_dir_done;
    logic signed [15:0]            w_dir_x;
    logic signed [15:0]            w_dir_y;

    // octave geometry from the octave number
    logic [GL:0]               w_pitch;
    logic [GL-1:0]             w_mask;
    logic [GL-1:0]             w_dx;
    logic [GL-1:0]             w_dy;
    logic [GL-1:0]             w_x1;
    logic [GL-1:0]             w_y1;
    logic [vn2d_pkg::SH_W-1:0] w_shift;

    always_comb begin
        w_pitch = PITCH0 >> r_oct;
        w_mask  = GL'(w_pitch - 1'b1);
        w_dx    = r_x & w_mask;
        w_dy    = r_y & w_mask;
        w_x1    = r_x & ~w_mask;
        w_y1    = r_y & ~w_mask;
        w_shift = SHIFT0 - {r_oct, 1'b0};
    end

    // corner select: bit 0 picks the right column, bit 1 the lower row
    logic [GL-1:0] w_cx;
    logic [GL-1:0] w_cy;
    logic [GL:0]   w_fx;
    logic [GL:0]   w_fy;

    assign w_cx = r_k[0] ? r_x2 : r_x1;
    assign w_cy = r_k[1] ? r_y2 : r_y1;
    assign w_fx = r_k[0] ? r_fx1 : r_fx0;
    assign w_fy = r_k[1] ? r_fy1 : r_fy0;

    // blended sample: round at half the pitch squared, then saturate
    logic [ACC_W-1:0] w_rnd;
    logic [ACC_W-1:0] w_smp_full;
    logic [15:0]      w_sample;

    always_comb begin
        w_rnd      = r_acc + ((ACC_W'(1) << r_shift) >> 1);
        w_smp_full = w_rnd >> r_shift;
        w_sample   = (|w_smp_full[ACC_W-1:16]) ? 16'hFFFF : w_smp_full[15:0];
    end

    assign w_last = (({1'b0, r_oct} + 4'd1) == {1'b0, r_cnt});

    // shared multiplier operands
    logic [vn2d_pkg::MUL_AW-1:0] w_mul_a;
    logic [vn2d_pkg::MUL_BW-1:0] w_mul_b;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            vn2d_pkg::ST_CW: begin
                w_mul_a = vn2d_pkg::MUL_AW'(w_fx);
                w_mul_b = vn2d_pkg::MUL_BW'(w_fy);
            end
            vn2d_pkg::ST_CS: begin
                w_mul_a = vn2d_pkg::MUL_AW'(w_rd_data);
                w_mul_b = r_prod[15:0];
            end
            vn2d_pkg::ST_SMP: begin
                w_mul_a = r_w;
                w_mul_b = w_sample;
            end
            default: begin
            end
        endcase
    end

    // divider requests: weight update after each sum but the last, normalization at the end
    always_comb begin
        w_div_req = '0;
        w_div_dvd = '0;
        w_div_dvs = '0;
        unique case (r_state)
            vn2d_pkg::ST_NACC: begin
                w_div_req.start = !w_last;
                w_div_req.iters = vn2d_pkg::W_DIV_ITERS;
                w_div_dvd       = {r_w, 20'd0};
                w_div_dvs       = vn2d_pkg::DIV_VW'(r_bias);
            end
            vn2d_pkg::ST_FGO: begin
                w_div_req.start = 1'b1;
                w_div_req.iters = vn2d_pkg::F_DIV_ITERS;
                w_div_dvd       = {1'b0, r_nsum} + DIV_DW'(r_wsum >> 1);
                w_div_dvs       = r_wsum;
            end
            default: begin
            end
        endcase
    end

    // sequencer: next state and strobes
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        w_dir_start   = 1'b0;
        w_ram_we      = 1'b0;
        unique case (r_state)
            vn2d_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (w_in_cmd == vn2d_pkg::CMD_WRITE) begin
                        w_ram_we = 1'b1;
                    end else if (r_cfg_oct == '0) begin
                        n_state = vn2d_pkg::ST_DGO;
                    end else begin
                        n_state = vn2d_pkg::ST_OCT;
                    end
                end
            end
            vn2d_pkg::ST_OCT: n_state = vn2d_pkg::ST_CW;
            vn2d_pkg::ST_CW:  n_state = vn2d_pkg::ST_CS;
            vn2d_pkg::ST_CS:  n_state = vn2d_pkg::ST_CA;
            vn2d_pkg::ST_CA: begin
                n_state = (r_k == 2'd3) ? vn2d_pkg::ST_SMP : vn2d_pkg::ST_CW;
            end
            vn2d_pkg::ST_SMP: n_state = vn2d_pkg::ST_NACC;
            vn2d_pkg::ST_NACC: begin
                n_state = w_last ? vn2d_pkg::ST_FGO : vn2d_pkg::ST_WDIV;
            end
            vn2d_pkg::ST_WDIV: begin
                if (w_div_done) begin
                    n_state = vn2d_pkg::ST_OCT;
                end
            end
            vn2d_pkg::ST_FGO: n_state = vn2d_pkg::ST_FDIV;
            vn2d_pkg::ST_FDIV: begin
                if (w_div_done) begin
                    n_state = vn2d_pkg::ST_DGO;
                end
            end
            vn2d_pkg::ST_DGO: begin
                w_dir_start = 1'b1;
                n_state     = vn2d_pkg::ST_DIR;
            end
            vn2d_pkg::ST_DIR: begin
                if (w_dir_done) begin
                    n_state = vn2d_pkg::ST_OUT;
                end
            end
            vn2d_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_out_load = 1'b1;
                    n_state    = vn2d_pkg::ST_IDLE;
                end
            end
            default: n_state = vn2d_pkg::ST_IDLE;
        endcase
    end

    // state, output valid and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vn2d_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_oct   <= vn2d_pkg::OCT_RESET;
            r_cfg_bias  <= vn2d_pkg::BIAS_RESET;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    vn2d_pkg::CFG_OCTAVE_COUNT: r_cfg_oct  <= i_cfg_data[2:0];
                    vn2d_pkg::CFG_SCALING_BIAS: r_cfg_bias <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // shared multiplier with its product register
    always_ff @(posedge i_clk) begin
        r_prod <= MUL_PW'(w_mul_a) * MUL_PW'(w_mul_b);
    end

    // octave datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            vn2d_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    r_x     <= w_in_x;
                    r_y     <= w_in_y;
                    r_cnt   <= r_cfg_oct;
                    r_bias  <= (r_cfg_bias < vn2d_pkg::MIN_BIAS) ?
                               vn2d_pkg::MIN_BIAS : r_cfg_bias;
                    r_oct   <= '0;
                    r_w     <= vn2d_pkg::W_ONE;
                    r_wsum  <= '0;
                    r_nsum  <= '0;
                    r_value <= '0;
                end
            end
            vn2d_pkg::ST_OCT: begin
                r_x1    <= w_x1;
                r_y1    <= w_y1;
                r_x2    <= w_x1 + w_pitch[GL-1:0];
                r_y2    <= w_y1 + w_pitch[GL-1:0];
                r_fx0   <= w_pitch - {1'b0, w_dx};
                r_fx1   <= {1'b0, w_dx};
                r_fy0   <= w_pitch - {1'b0, w_dy};
                r_fy1   <= {1'b0, w_dy};
                r_shift <= w_shift;
                r_acc   <= '0;
                r_k     <= '0;
            end
            vn2d_pkg::ST_CA: begin
                r_acc <= r_acc + r_prod[ACC_W-1:0];
                r_k   <= r_k + 1'b1;
            end
            vn2d_pkg::ST_NACC: begin
                r_nsum <= r_nsum + vn2d_pkg::NSUM_W'(r_prod);
                r_wsum <= r_wsum + vn2d_pkg::WSUM_W'(r_w);
            end
            vn2d_pkg::ST_WDIV: begin
                if (w_div_done) begin
                    r_w   <= (|w_div_quo[DIV_DW-1:32]) ? '1 : w_div_quo[31:0];
                    r_oct <= r_oct + 1'b1;
                end
            end
            vn2d_pkg::ST_FDIV: begin
                if (w_div_done) begin
                    r_value <= (|w_div_quo[DIV_DW-1:16]) ? 16'hFFFF : w_div_quo[15:0];
                end
            end
            default: begin
            end
        endcase
        if (w_out_load) begin
            r_out_data <= {w_dir_y, w_dir_x, r_value};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign o_cfg_ready   = 1'b1;

    vn2d_seed_ram u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr ({w_in_y, w_in_x}),
        .i_wdata (w_in_seed),
        .i_raddr ({w_cy, w_cx}),
        .o_rdata (w_rd_data)
    );

    vn2d_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quotient (w_div_quo),
        .o_done     (w_div_done),
        .o_busy     (w_div_busy)
    );

    vn2d_dir_lut #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dir_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dir_start),
        .i_value (r_value),
        .o_done  (w_dir_done),
        .o_dir_x (w_dir_x),
        .o_dir_y (w_dir_y)
    );

    // divider must be idle whenever a new item can enter
    `VN2D_ASSERT_IMP(a_ready_div_idle, i_clk, i_rst_n, s_axis_tready, !w_div_busy, "item taken while divider busy")
    // divider completion only lands in a waiting state
    `VN2D_ASSERT_IMP(a_div_done_state, i_clk, i_rst_n, w_div_done, (r_state == vn2d_pkg::ST_WDIV || r_state == vn2d_pkg::ST_FDIV), "divider done outside wait state")
    // octave number stays below the latched count
    `VN2D_ASSERT_IMP(a_oct_range, i_clk, i_rst_n, (r_state == vn2d_pkg::ST_OCT), (r_oct < r_cnt), "octave index past count")
    // a new result appears only from the output state
    `VN2D_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == vn2d_pkg::ST_OUT), "result valid without sequencer load")

endmodule
